// ----- rtl/wsfd_pkg.sv -----
// Package for the WebSocket frame deframer: shared types, codes and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package wsfd_pkg;

    localparam int unsigned CfgDataW = 32;
    localparam int unsigned CfgAddrW = 3;
    localparam logic [CfgDataW-1:0] MAX_LEN_RESET = 32'h0100_0000;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
    localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
    localparam logic [2:0] MASK_BYTES_M1  = 3'd3;

    localparam logic REG_MAX_LEN = 1'b0;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_MASK,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_EMPTY,
        KIND_STOP
    } t_kind;

    typedef enum logic [1:0] {
        ROUTE_BINARY,
        ROUTE_TEXT,
        ROUTE_PONG
    } t_route;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NOT_FINAL,
        ST_BAD_OPCODE,
        ST_UNMASKED,
        ST_TOO_LONG,
        ST_CLOSE
    } t_status;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        t_route     route;
        logic       frame_last;
        t_status    status;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result result;
    } t_parse_out;

    function automatic t_route route_of(input logic [3:0] op);
        t_route r;
        r = ROUTE_BINARY;
        if (op == OP_TEXT) begin
            r = ROUTE_TEXT;
        end else if (op == OP_PING) begin
            r = ROUTE_PONG;
        end
        return r;
    endfunction

endpackage

// ----- rtl/wsfd_if.sv -----
// Valid/ready channel interfaces for the deframer: raw input bytes and result items.
// Depends on nothing; the payload fields carry the widths of the item fields.
`timescale 1ns / 1ps

interface wsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface wsfd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [1:0] route;
    logic       frame_last;
    logic [2:0] status;

    modport source (output valid, output kind, output data_byte, output route,
                    output frame_last, output status, input ready);
    modport sink (input valid, input kind, input data_byte, input route,
                  input frame_last, input status, output ready);
endinterface

// ----- rtl/wsfd_apb_regs.sv -----
// APB-style configuration register file holding the maximum payload length.
// Depends on wsfd_pkg for the register index and reset value.
`timescale 1ns / 1ps

module wsfd_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsfd_pkg::CfgAddrW-1:0] paddr,
    input  logic [wsfd_pkg::CfgDataW-1:0] pwdata,
    output logic [wsfd_pkg::CfgDataW-1:0] prdata,
    output logic                          pready,
    output logic [wsfd_pkg::CfgDataW-1:0] o_max_len
);
    import wsfd_pkg::*;

    logic [CfgDataW-1:0] r_max_len;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (wr_en && (paddr[CfgAddrW-1] == REG_MAX_LEN)) begin
            r_max_len <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[CfgAddrW-1] == REG_MAX_LEN) begin
            prdata = r_max_len;
        end
    end

    assign o_max_len = r_max_len;

endmodule

// ----- rtl/wsfd_parser.sv -----
// Frame parser: header, extended length and mask key state, payload unmasking.
// Depends on wsfd_pkg; state advances once per byte when i_fire is high.
`timescale 1ns / 1ps

module wsfd_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [7:0]                    i_byte,
    input  logic [wsfd_pkg::CfgDataW-1:0] i_max_len,
    output wsfd_pkg::t_parse_out          o_parse
);
    import wsfd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic [63:0] r_len, n_len;
    logic [2:0]  r_hbc, n_hbc;
    logic [31:0] r_mask, n_mask;
    logic [63:0] r_count, n_count;
    logic        r_halted, n_halted;

    logic [7:0]  key;
    logic        last;
    logic        too_long;
    t_parse_out  po;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= '0;
            r_len    <= '0;
            r_hbc    <= '0;
            r_mask   <= '0;
            r_count  <= '0;
            r_halted <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_len    <= n_len;
            r_hbc    <= n_hbc;
            r_mask   <= n_mask;
            r_count  <= n_count;
            r_halted <= n_halted;
        end
    end

    always_comb begin
        case (r_count[1:0])
            2'd0:    key = r_mask[31:24];
            2'd1:    key = r_mask[23:16];
            2'd2:    key = r_mask[15:8];
            default: key = r_mask[7:0];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_len    = r_len;
        n_hbc    = r_hbc;
        n_mask   = r_mask;
        n_count  = r_count;
        n_halted = r_halted;
        po       = '0;
        last     = 1'b0;
        too_long = 1'b0;

        if (!r_halted) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_opcode = i_byte[3:0];
                    if (!i_byte[7]) begin
                        n_halted         = 1'b1;
                        po.emit          = 1'b1;
                        po.result.kind   = KIND_STOP;
                        po.result.frame_last = 1'b1;
                        po.result.status = ST_NOT_FINAL;
                    end else if (n_opcode != OP_TEXT && n_opcode != OP_BINARY &&
                                 n_opcode != OP_CLOSE && n_opcode != OP_PING) begin
                        n_halted         = 1'b1;
                        po.emit          = 1'b1;
                        po.result.kind   = KIND_STOP;
                        po.result.frame_last = 1'b1;
                        po.result.status = ST_BAD_OPCODE;
                    end else begin
                        n_phase = PH_HDR1;
                    end
                end
                PH_HDR1: begin
                    if (!i_byte[7]) begin
                        n_halted         = 1'b1;
                        po.emit          = 1'b1;
                        po.result.kind   = KIND_STOP;
                        po.result.frame_last = 1'b1;
                        po.result.status = ST_UNMASKED;
                    end else if (i_byte[6:0] == LEN_EXT16) begin
                        n_len   = '0;
                        n_phase = PH_EXT;
                        n_hbc   = EXT16_BYTES_M1;
                    end else if (i_byte[6:0] == LEN_EXT64) begin
                        n_len   = '0;
                        n_phase = PH_EXT;
                        n_hbc   = EXT64_BYTES_M1;
                    end else begin
                        n_len    = {57'd0, i_byte[6:0]};
                        too_long = n_len > {32'd0, i_max_len};
                        if (too_long) begin
                            n_halted         = 1'b1;
                            po.emit          = 1'b1;
                            po.result.kind   = KIND_STOP;
                            po.result.frame_last = 1'b1;
                            po.result.status = ST_TOO_LONG;
                        end else begin
                            n_phase = PH_MASK;
                            n_hbc   = MASK_BYTES_M1;
                        end
                    end
                end
                PH_EXT: begin
                    n_len = {r_len[55:0], i_byte};
                    if (r_hbc == 3'd0) begin
                        too_long = n_len > {32'd0, i_max_len};
                        if (too_long) begin
                            n_halted         = 1'b1;
                            po.emit          = 1'b1;
                            po.result.kind   = KIND_STOP;
                            po.result.frame_last = 1'b1;
                            po.result.status = ST_TOO_LONG;
                        end else begin
                            n_phase = PH_MASK;
                            n_hbc   = MASK_BYTES_M1;
                        end
                    end else begin
                        n_hbc = r_hbc - 3'd1;
                    end
                end
                PH_MASK: begin
                    n_mask = {r_mask[23:0], i_byte};
                    if (r_hbc != 3'd0) begin
                        n_hbc = r_hbc - 3'd1;
                    end else begin
                        n_count = '0;
                        if (r_len != 64'd0) begin
                            n_phase = PH_PAYLOAD;
                        end else begin
                            n_phase = PH_HDR0;
                            po.emit = 1'b1;
                            po.result.frame_last = 1'b1;
                            if (r_opcode == OP_CLOSE) begin
                                n_halted         = 1'b1;
                                po.result.kind   = KIND_STOP;
                                po.result.status = ST_CLOSE;
                            end else begin
                                po.result.kind  = KIND_EMPTY;
                                po.result.route = route_of(r_opcode);
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_count = r_count + 64'd1;
                    last    = (n_count == r_len);
                    if (last) begin
                        n_phase = PH_HDR0;
                    end
                    if (r_opcode == OP_CLOSE) begin
                        if (last) begin
                            n_halted         = 1'b1;
                            po.emit          = 1'b1;
                            po.result.kind   = KIND_STOP;
                            po.result.frame_last = 1'b1;
                            po.result.status = ST_CLOSE;
                        end
                    end else begin
                        po.emit              = 1'b1;
                        po.result.kind       = KIND_DATA;
                        po.result.data_byte  = i_byte ^ key;
                        po.result.route      = route_of(r_opcode);
                        po.result.frame_last = last;
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase
        end
    end

    assign o_parse = po;

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted flag cleared without reset");

    a_no_emit_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !po.emit)
        else $error("result produced while halted");

    a_stop_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && po.emit && po.result.kind == KIND_STOP) |=> r_halted)
        else $error("stop result did not halt the parser");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_count < r_len))
        else $error("payload count reached frame length inside payload");

endmodule

// ----- rtl/websocket_frame_deframer_core.sv -----
// Top level of the WebSocket client-to-server frame deframer.
// Depends on wsfd_pkg, wsfd_if, wsfd_apb_regs and wsfd_parser.
//
// Raw client bytes enter on i_byte_ch, one item per byte. Result items leave
// on o_res_ch: unmasked payload bytes tagged with a route, empty-frame
// markers, and one final stop item carrying a status.
// The maximum payload length is written through the APB port at address 0.
// Each byte is held in an input register, parsed by short logic, and its
// result is loaded into an output register. One byte is taken every cycle
// unless a byte with a result waits for the output register; header bytes,
// mask bytes and close-frame payload give no result and pass at the same rate.
// The output register is the only result buffer. While the receiver stalls,
// bytes that give no result are still consumed, and one further byte waits in
// the input register; a byte that needs the output waits until it frees.
// After a protocol error or a completed close frame the block drops every
// byte until reset. Synchronous reset returns the parser to the first header
// byte and the length limit to 16 MiB; it empties both registers.
`timescale 1ns / 1ps

module websocket_frame_deframer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wsfd_in_if.sink                       i_byte_ch,
    wsfd_out_if.source                    o_res_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsfd_pkg::CfgAddrW-1:0] paddr,
    input  logic [wsfd_pkg::CfgDataW-1:0] pwdata,
    output logic [wsfd_pkg::CfgDataW-1:0] prdata,
    output logic                          pready
);
    import wsfd_pkg::*;

    logic [CfgDataW-1:0] max_len;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_out_valid;
    t_result             r_out;
    t_parse_out          parse;
    logic                out_free;
    logic                fire;

    wsfd_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (max_len)
    );

    wsfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (r_in_byte),
        .i_max_len (max_len),
        .o_parse   (parse)
    );

    assign out_free        = !r_out_valid || o_res_ch.ready;
    assign fire            = r_in_valid && (!parse.emit || out_free);
    assign i_byte_ch.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte_ch.ready) begin
            r_in_valid <= i_byte_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_ch.ready && i_byte_ch.valid) begin
            r_in_byte <= i_byte_ch.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && parse.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && parse.emit) begin
            r_out <= parse.result;
        end
    end

    assign o_res_ch.valid      = r_out_valid;
    assign o_res_ch.kind       = r_out.kind;
    assign o_res_ch.data_byte  = r_out.data_byte;
    assign o_res_ch.route      = r_out.route;
    assign o_res_ch.frame_last = r_out.frame_last;
    assign o_res_ch.status     = r_out.status;

endmodule
